FILE: rtl/core/segment_corner_intersect_unit_assert.svh
// Assertion macros shared by the segment corner intersect RTL.
`ifndef SEGMENT_CORNER_INTERSECT_UNIT_ASSERT_SVH
`define SEGMENT_CORNER_INTERSECT_UNIT_ASSERT_SVH

// Invariant checked at every clock edge outside reset.
`define SCI_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define SCI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/sci_pkg.sv
// Types, widths, codes and arithmetic helpers of the segment corner intersect unit.
`default_nettype none
package sci_pkg;

  localparam int COORD_BITS = 15;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * COORD_BITS + 1;
  localparam int LEN_W      = 2 * DIFF_W;
  localparam int DEN_W      = LEN_W + 1;
  localparam int NUM_W      = PROD_W + DIFF_W + 1;
  localparam int MAG_W      = NUM_W - 1;
  localparam int SQ_W       = 2 * LEN_W;
  localparam int LIM_W      = 16;
  localparam int LIMSQ_W    = 2 * LIM_W;
  localparam int RHSP_W     = LIMSQ_W + LEN_W;
  localparam int CMP_W      = SQ_W + LIMSQ_W;
  localparam int GAP_W      = 10;
  localparam int GAPSQ_W    = 2 * GAP_W;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAP = CFG_IDX_W'(1);
  localparam logic [LIM_W-1:0] COS_LIMIT_RST = LIM_W'(11141);
  localparam logic [GAP_W-1:0] MAX_GAP_RST   = GAP_W'(10);

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [DEN_W-1:0]      den_t;
  typedef logic signed [NUM_W-1:0]      num_t;
  typedef logic [LEN_W-1:0]             len_t;
  typedef logic [MAG_W-1:0]             mag_t;
  typedef logic [SQ_W-1:0]              sq_t;
  typedef logic [RHSP_W-1:0]            rhsp_t;
  typedef logic [CMP_W-1:0]             cmp_t;
  typedef logic [COORD_BITS-1:0]        quo_t;

  localparam coord_t COORD_MAX = coord_t'((1 << (COORD_BITS - 1)) - 1);
  localparam coord_t COORD_MIN = coord_t'(1 << (COORD_BITS - 1));
  localparam quo_t   Q_HALF    = quo_t'(1 << (COORD_BITS - 1));

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_PERP = 2'd1,
    ST_TOO_FAR  = 2'd2,
    ST_ZERO_LEN = 2'd3
  } status_t;

  typedef struct packed {
    logic [LIM_W-1:0] cos_limit_q16;
    logic [GAP_W-1:0] max_endpoint_gap;
  } cfg_t;

  // One classified pair handed from the front to the divider back end.
  typedef struct packed {
    status_t status;
    mag_t    num_x_mag;
    mag_t    num_y_mag;
    logic    neg_x;
    logic    neg_y;
    len_t    den_mag;
  } qent_t;

  function automatic len_t sq_diff(diff_t v);
    logic signed [LEN_W-1:0] w;
    w = LEN_W'(v);
    return len_t'(w * w);
  endfunction

  function automatic den_t mul_dd(diff_t a, diff_t b);
    return den_t'(a) * den_t'(b);
  endfunction

  function automatic prod_t mul_cc(coord_t a, coord_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  function automatic num_t mul_pd(prod_t p, diff_t d);
    return num_t'(p) * num_t'(d);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sci_if.sv
// Channel interfaces: input pair, result and configuration write.
`default_nettype none
interface sci_in_if;
  import sci_pkg::*;
  logic   valid;
  logic   ready;
  coord_t first_ax;
  coord_t first_ay;
  coord_t first_bx;
  coord_t first_by;
  coord_t second_ax;
  coord_t second_ay;
  coord_t second_bx;
  coord_t second_by;
  modport source(output valid, first_ax, first_ay, first_bx, first_by,
                 second_ax, second_ay, second_bx, second_by, input ready);
  modport sink(input valid, first_ax, first_ay, first_bx, first_by,
               second_ax, second_ay, second_bx, second_by, output ready);
endinterface

interface sci_out_if;
  import sci_pkg::*;
  logic       valid;
  logic       ready;
  logic       crossed;
  logic [1:0] status;
  coord_t     cross_x;
  coord_t     cross_y;
  modport source(output valid, crossed, status, cross_x, cross_y, input ready);
  modport sink(input valid, crossed, status, cross_x, cross_y, output ready);
endinterface

interface sci_cfg_if;
  import sci_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sci_front.sv
// Front end: accepts pairs, runs the length, angle and gap tests, forms the quotient operands.
`default_nettype none
module sci_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sci_pkg::cfg_t cfg,
  sci_in_if.sink             in_ch,
  input  wire logic          q_full,
  output logic               q_push,
  output sci_pkg::qent_t     q_data
);
  import sci_pkg::*;

  logic adv;
  logic va_r, vb_r, vc_r, vd_r, ve_r;

  // stage A: coordinates and differences
  coord_t x1_r, y1_r, x2_r, y2_r, x3_r, y3_r, x4_r, y4_r;
  diff_t  dx1_r, dy1_r, dx2_r, dy2_r;
  diff_t  ex_r [4];
  diff_t  ey_r [4];
  // stage B: squares and cross terms
  len_t   len1_r, len2_r;
  den_t   dot_r, den_b_r;
  prod_t  a_r, b_r;
  len_t   dist_r [4];
  diff_t  dx1b_r, dy1b_r, dx2b_r, dy2b_r;
  // stage C
  sq_t    dotsq_r, lensq_r;
  logic [LIMSQ_W-1:0] limsq_r;
  logic   zero_c_r, far_c_r, denz_c_r, denn_c_r;
  len_t   denm_c_r;
  num_t   ax_r, bx_r, ay_r, by_r;
  // stage D
  sq_t    dotsq_d_r;
  rhsp_t  rhs_lo_r, rhs_hi_r;
  logic   zero_d_r, far_d_r, denz_d_r, denn_d_r;
  len_t   denm_d_r;
  num_t   numx_r, numy_r;
  // stage E
  qent_t  ent_r;

  len_t   dot_abs, dmin01, dmin23, dmin;
  logic [GAPSQ_W-1:0] gapsq;
  cmp_t   lhs, rhs;
  logic   not_perp;
  status_t st_e;

  assign adv         = !ve_r || !q_full;
  assign in_ch.ready = adv;
  assign q_push      = ve_r && !q_full;
  assign q_data      = ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_ch.valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  always_comb begin
    dot_abs  = dot_r[DEN_W-1] ? len_t'(-dot_r) : len_t'(dot_r);
    dmin01   = (dist_r[1] < dist_r[0]) ? dist_r[1] : dist_r[0];
    dmin23   = (dist_r[3] < dist_r[2]) ? dist_r[3] : dist_r[2];
    dmin     = (dmin23 < dmin01) ? dmin23 : dmin01;
    gapsq    = GAPSQ_W'(cfg.max_endpoint_gap) * GAPSQ_W'(cfg.max_endpoint_gap);
    // dot^2 * 2^32 against limit^2 * len1 * len2
    lhs      = {dotsq_d_r, LIMSQ_W'(0)};
    rhs      = {rhs_hi_r, LEN_W'(0)} + cmp_t'(rhs_lo_r);
    not_perp = lhs > rhs;
    if (zero_d_r)      st_e = ST_ZERO_LEN;
    else if (not_perp) st_e = ST_NOT_PERP;
    else if (far_d_r)  st_e = ST_TOO_FAR;
    else if (denz_d_r) st_e = ST_NOT_PERP;  // parallel lines
    else               st_e = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r  <= in_ch.first_ax;
      y1_r  <= in_ch.first_ay;
      x2_r  <= in_ch.first_bx;
      y2_r  <= in_ch.first_by;
      x3_r  <= in_ch.second_ax;
      y3_r  <= in_ch.second_ay;
      x4_r  <= in_ch.second_bx;
      y4_r  <= in_ch.second_by;
      dx1_r <= diff_t'(in_ch.first_ax) - diff_t'(in_ch.first_bx);
      dy1_r <= diff_t'(in_ch.first_ay) - diff_t'(in_ch.first_by);
      dx2_r <= diff_t'(in_ch.second_ax) - diff_t'(in_ch.second_bx);
      dy2_r <= diff_t'(in_ch.second_ay) - diff_t'(in_ch.second_by);
      ex_r[0] <= diff_t'(in_ch.first_ax) - diff_t'(in_ch.second_ax);
      ey_r[0] <= diff_t'(in_ch.first_ay) - diff_t'(in_ch.second_ay);
      ex_r[1] <= diff_t'(in_ch.first_bx) - diff_t'(in_ch.second_ax);
      ey_r[1] <= diff_t'(in_ch.first_by) - diff_t'(in_ch.second_ay);
      ex_r[2] <= diff_t'(in_ch.first_ax) - diff_t'(in_ch.second_bx);
      ey_r[2] <= diff_t'(in_ch.first_ay) - diff_t'(in_ch.second_by);
      ex_r[3] <= diff_t'(in_ch.first_bx) - diff_t'(in_ch.second_bx);
      ey_r[3] <= diff_t'(in_ch.first_by) - diff_t'(in_ch.second_by);

      len1_r  <= sq_diff(dx1_r) + sq_diff(dy1_r);
      len2_r  <= sq_diff(dx2_r) + sq_diff(dy2_r);
      dot_r   <= mul_dd(dx1_r, dx2_r) + mul_dd(dy1_r, dy2_r);
      den_b_r <= mul_dd(dx1_r, dy2_r) - mul_dd(dy1_r, dx2_r);
      a_r     <= mul_cc(x1_r, y2_r) - mul_cc(y1_r, x2_r);
      b_r     <= mul_cc(x3_r, y4_r) - mul_cc(y3_r, x4_r);
      for (int k = 0; k < 4; k++) begin
        dist_r[k] <= sq_diff(ex_r[k]) + sq_diff(ey_r[k]);
      end
      dx1b_r <= dx1_r;
      dy1b_r <= dy1_r;
      dx2b_r <= dx2_r;
      dy2b_r <= dy2_r;

      dotsq_r  <= sq_t'(dot_abs) * sq_t'(dot_abs);
      lensq_r  <= sq_t'(len1_r) * sq_t'(len2_r);
      limsq_r  <= LIMSQ_W'(cfg.cos_limit_q16) * LIMSQ_W'(cfg.cos_limit_q16);
      zero_c_r <= (len1_r == '0) || (len2_r == '0);
      far_c_r  <= dmin > len_t'(gapsq);
      denz_c_r <= den_b_r == '0;
      denn_c_r <= den_b_r[DEN_W-1];
      denm_c_r <= den_b_r[DEN_W-1] ? len_t'(-den_b_r) : len_t'(den_b_r);
      ax_r     <= mul_pd(a_r, dx2b_r);
      bx_r     <= mul_pd(b_r, dx1b_r);
      ay_r     <= mul_pd(a_r, dy2b_r);
      by_r     <= mul_pd(b_r, dy1b_r);

      dotsq_d_r <= dotsq_r;
      rhs_lo_r  <= rhsp_t'(limsq_r) * rhsp_t'(lensq_r[LEN_W-1:0]);
      rhs_hi_r  <= rhsp_t'(limsq_r) * rhsp_t'(lensq_r[SQ_W-1:LEN_W]);
      zero_d_r  <= zero_c_r;
      far_d_r   <= far_c_r;
      denz_d_r  <= denz_c_r;
      denn_d_r  <= denn_c_r;
      denm_d_r  <= denm_c_r;
      numx_r    <= ax_r - bx_r;
      numy_r    <= ay_r - by_r;

      ent_r.status    <= st_e;
      ent_r.num_x_mag <= numx_r[NUM_W-1] ? mag_t'(-numx_r) : mag_t'(numx_r);
      ent_r.num_y_mag <= numy_r[NUM_W-1] ? mag_t'(-numy_r) : mag_t'(numy_r);
      ent_r.neg_x     <= numx_r[NUM_W-1] ^ denn_d_r;
      ent_r.neg_y     <= numy_r[NUM_W-1] ^ denn_d_r;
      ent_r.den_mag   <= denm_d_r;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sci_queue.sv
// Short register queue between the classifying front end and the divider back end.
`default_nettype none
`include "segment_corner_intersect_unit_assert.svh"
module sci_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire sci_pkg::qent_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output sci_pkg::qent_t      pop_data
);
  import sci_pkg::*;

  qent_t                mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full      = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign not_empty = cnt_r != '0;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + Q_CNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  `SCI_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= Q_CNT_W'(Q_DEPTH), "queue count overflow")
  `SCI_ASSERT_NEXT(a_cnt_inc, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + Q_CNT_W'(1), "count did not grow")
  `SCI_ASSERT_NEXT(a_cnt_dec, clk, rst_n, pop && !push, cnt_r == $past(cnt_r) - Q_CNT_W'(1), "count did not shrink")

endmodule
`default_nettype wire

FILE: rtl/core/sci_back.sv
// Back end: pipelined restoring divider, one quotient bit per stage, with saturation.
`default_nettype none
module sci_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire sci_pkg::qent_t q_data,
  output logic                q_pop,
  sci_out_if.source           out_ch
);
  import sci_pkg::*;

  localparam int NS = COORD_BITS;

  logic    adv;
  logic    v_r    [0:NS];
  status_t st_r   [0:NS];
  mag_t    remx_r [0:NS];
  mag_t    remy_r [0:NS];
  quo_t    qx_r   [0:NS];
  quo_t    qy_r   [0:NS];
  len_t    d_r    [0:NS];
  logic    negx_r [0:NS];
  logic    negy_r [0:NS];
  logic    satx_r [0:NS];
  logic    saty_r [0:NS];

  mag_t    remx_nxt [1:NS];
  mag_t    remy_nxt [1:NS];
  quo_t    qx_nxt   [1:NS];
  quo_t    qy_nxt   [1:NS];
  logic    gex, gey;

  logic    out_valid_r;
  logic    out_crossed_r;
  status_t out_status_r;
  coord_t  out_x_r, out_y_r;

  function automatic coord_t sat_coord(quo_t q, logic neg, logic sat);
    coord_t r;
    if (sat)                r = neg ? COORD_MIN : COORD_MAX;
    else if (neg && q > Q_HALF) r = COORD_MIN;
    else if (neg)           r = coord_t'(-q);
    else if (q > quo_t'(COORD_MAX)) r = COORD_MAX;
    else                    r = coord_t'(q);
    return r;
  endfunction

  assign adv            = !out_valid_r || out_ch.ready;
  assign q_pop          = q_valid && adv;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.crossed = out_crossed_r;
  assign out_ch.status  = 2'(out_status_r);
  assign out_ch.cross_x = out_x_r;
  assign out_ch.cross_y = out_y_r;

  always_comb begin
    gex = 1'b0;
    gey = 1'b0;
    for (int k = 1; k <= NS; k++) begin
      gex = remx_r[k-1] >= (mag_t'(d_r[k-1]) << (NS - k));
      gey = remy_r[k-1] >= (mag_t'(d_r[k-1]) << (NS - k));
      remx_nxt[k] = gex ? remx_r[k-1] - (mag_t'(d_r[k-1]) << (NS - k)) : remx_r[k-1];
      remy_nxt[k] = gey ? remy_r[k-1] - (mag_t'(d_r[k-1]) << (NS - k)) : remy_r[k-1];
      qx_nxt[k] = qx_r[k-1];
      qy_nxt[k] = qy_r[k-1];
      qx_nxt[k][NS-k] = gex;
      qy_nxt[k][NS-k] = gey;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NS; k++) v_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r[0] <= q_valid;
      for (int k = 1; k <= NS; k++) v_r[k] <= v_r[k-1];
      out_valid_r <= v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 0: quotient of 2^COORD_BITS or more always saturates
      st_r[0]   <= q_data.status;
      remx_r[0] <= q_data.num_x_mag;
      remy_r[0] <= q_data.num_y_mag;
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      d_r[0]    <= q_data.den_mag;
      negx_r[0] <= q_data.neg_x;
      negy_r[0] <= q_data.neg_y;
      satx_r[0] <= q_data.num_x_mag >= (mag_t'(q_data.den_mag) << NS);
      saty_r[0] <= q_data.num_y_mag >= (mag_t'(q_data.den_mag) << NS);
      for (int k = 1; k <= NS; k++) begin
        st_r[k]   <= st_r[k-1];
        remx_r[k] <= remx_nxt[k];
        remy_r[k] <= remy_nxt[k];
        qx_r[k]   <= qx_nxt[k];
        qy_r[k]   <= qy_nxt[k];
        d_r[k]    <= d_r[k-1];
        negx_r[k] <= negx_r[k-1];
        negy_r[k] <= negy_r[k-1];
        satx_r[k] <= satx_r[k-1];
        saty_r[k] <= saty_r[k-1];
      end
      out_crossed_r <= st_r[NS] == ST_OK;
      out_status_r  <= st_r[NS];
      out_x_r <= (st_r[NS] == ST_OK) ? sat_coord(qx_r[NS], negx_r[NS], satx_r[NS]) : '0;
      out_y_r <= (st_r[NS] == ST_OK) ? sat_coord(qy_r[NS], negy_r[NS], saty_r[NS]) : '0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/segment_corner_intersect_unit.sv
// Top level of the segment corner intersect unit.
// Usage:
//  in_ch  : one transfer carries two segments (four signed endpoints).
//  out_ch : one result per pair: crossed, status, cross_x, cross_y.
//  cfg_ch : register writes, index 0 cos_limit_q16, index 1 max_endpoint_gap;
//           always ready, other indexes are dropped. Write only while idle.
// Rate: one pair per cycle sustained while out_ch.ready stays high. Path from
//  input transfer to result valid: 5 front stages (tests and operand prep),
//  the queue register, COORD_BITS+1 divider stages, output register.
//  The divider takes one quotient bit per stage, which sets the depth.
// Status: zero length first, then angle, then endpoint gap; parallel lines
//  report not perpendicular. Point is 0 when not crossed, else saturated.
// Reset: rst_n synchronous, clears all valid flags and the queue, and loads
//  cos_limit_q16 = 11141 (about 0.17) and max_endpoint_gap = 10.
// Stall: when out_ch.ready is low the divider freezes, the 4-entry queue
//  fills, then the front freezes and in_ch.ready drops; nothing is lost.
`default_nettype none
module segment_corner_intersect_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  sci_in_if.sink    in_ch,
  sci_out_if.source out_ch,
  sci_cfg_if.sink   cfg_ch
);
  import sci_pkg::*;

  cfg_t  cfg_r;
  logic  q_push, q_full, q_pop, q_valid;
  qent_t q_in, q_out;

  // configuration registers; every write transfer completes at once
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_limit_q16    <= COS_LIMIT_RST;
      cfg_r.max_endpoint_gap <= MAX_GAP_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_IDX_COS) cfg_r.cos_limit_q16 <= cfg_ch.data[LIM_W-1:0];
      if (cfg_ch.index == CFG_IDX_GAP) cfg_r.max_endpoint_gap <= cfg_ch.data[GAP_W-1:0];
    end
  end

  // front: classify and form quotient operands
  sci_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  // decoupling queue
  sci_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  // back: divide, saturate, present result
  sci_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire
